/* design/rotary_embedding_pair_rotate_macros.svh */
// Assertion macros for the rotary embedding RTL.
`ifndef ROTARY_EMBEDDING_PAIR_ROTATE_MACROS_SVH
`define ROTARY_EMBEDDING_PAIR_ROTATE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ROPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ROPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rope_pkg.sv */
// Shared types and constants for the rotary embedding pair rotator.
package rope_pkg;

    localparam int DATA_W        = 16;
    localparam int IDX_W         = 7;
    localparam int HALF_W        = 7;
    localparam int POS_W         = 8;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int ENTRY_W       = 3 * DATA_W;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int MAX_PAIRS_DEF = 64;
    localparam logic [HALF_W-1:0] HALF_RESET = 7'd64;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_MODE = 1'b0,
        REG_HALF = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        OUT_EMPTY,
        OUT_FIRST,
        OUT_SECOND
    } out_state_t;

    // Per-element sequencing info from the position tracker
    typedef struct packed
    {
        logic             is_first;
        logic             last;
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] second_idx;
    } seq_info_t;

endpackage

/* design/rope_mem.sv */
// Pair buffer: one write port, one registered read port.
module rope_mem
    import rope_pkg::*;
#(
    parameter int DEPTH  = MAX_PAIRS_DEF,
    parameter int ADDR_W = 6
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/rope_seq.sv */
// Position tracker: pairing, buffer slot and result indices per element.
module rope_seq
    import rope_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF,
    parameter int SLOT_W    = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              interleaved_mode,
    input  logic [HALF_W-1:0] half_length,
    input  logic              fire,
    output seq_info_t         info,
    output logic [SLOT_W-1:0] slot
);

    localparam logic [HALF_W-1:0] H_CAP = HALF_W'((MAX_PAIRS < 127) ? MAX_PAIRS : 127);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [HALF_W-1:0] h_eff;
    logic [POS_W-1:0]  h_ext;
    logic [POS_W-1:0]  total;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  slot_full;
    logic [POS_W-1:0]  first_full;
    logic [POS_W-1:0]  second_full;
    logic              is_first;

    always_comb
    begin
        if (half_length == '0)
        begin
            h_eff = HALF_W'(1);
        end
        else if (half_length > H_CAP)
        begin
            h_eff = H_CAP;
        end
        else
        begin
            h_eff = half_length;
        end
        h_ext   = {1'b0, h_eff};
        total   = {h_eff, 1'b0};
        // A vector shrunk under the current position restarts at zero
        pos     = (pos_reg >= total) ? '0 : pos_reg;
        pos_inc = pos + POS_W'(1);

        if (interleaved_mode)
        begin
            is_first    = ~pos[0];
            slot_full   = pos >> 1;
            first_full  = {pos[POS_W-1:1], 1'b0};
            second_full = {pos[POS_W-1:1], 1'b1};
        end
        else
        begin
            is_first    = (pos < h_ext);
            slot_full   = is_first ? pos : (pos - h_ext);
            first_full  = slot_full;
            second_full = slot_full + h_ext;
        end

        pos_next = (pos_inc >= total) ? '0 : pos_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
        end
    end

    assign slot            = SLOT_W'(slot_full);
    assign info.is_first   = is_first;
    assign info.last       = (pos_inc == total);
    assign info.first_idx  = first_full[IDX_W-1:0];
    assign info.second_idx = second_full[IDX_W-1:0];

endmodule

/* design/rope_dp.sv */
// Rotation datapath: align, multiply, round and saturate, two-result output stage.
module rope_dp
    import rope_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      a_load,
    input  seq_info_t                 a_info,
    input  logic signed [DATA_W-1:0]  b_in,
    input  logic [ENTRY_W-1:0]        entry,
    output logic                      a_en,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic signed [DATA_W-1:0]  rotated_value,
    output logic [IDX_W-1:0]          elem_index,
    output logic                      vector_done
);

    `include "rotary_embedding_pair_rotate_macros.svh"

    localparam int SUM_W = PROD_W + 1;
    localparam int RND_W = SUM_W + 1;
    localparam int SH_W  = RND_W - 14;

    // Stage A: second element, aligned with the buffer read
    logic                     a_valid_reg;
    logic signed [DATA_W-1:0] b_reg;
    seq_info_t                a_info_reg;

    // Stage B: products
    logic                     b_valid_reg;
    logic signed [PROD_W-1:0] p_ac_reg;
    logic signed [PROD_W-1:0] p_bs_reg;
    logic signed [PROD_W-1:0] p_as_reg;
    logic signed [PROD_W-1:0] p_bc_reg;
    seq_info_t                b_info_reg;

    // Output pair
    out_state_t               state_reg;
    out_state_t               state_next;
    logic signed [DATA_W-1:0] rot1_reg;
    logic signed [DATA_W-1:0] rot2_reg;
    seq_info_t                o_info_reg;

    logic                     o_load;
    logic                     b_en;
    logic signed [DATA_W-1:0] ea;
    logic signed [DATA_W-1:0] es;
    logic signed [DATA_W-1:0] ec;
    logic signed [SUM_W-1:0]  sum1;
    logic signed [SUM_W-1:0]  sum2;
    logic signed [DATA_W-1:0] rot1;
    logic signed [DATA_W-1:0] rot2;

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [RND_W-1:0] r;
        logic signed [SH_W-1:0]  q;
        begin
            r = RND_W'(s) + RND_W'(8192);
            q = SH_W'(r >>> 14);
            if (q > SH_W'(32767))
            begin
                round_sat = 16'sh7fff;
            end
            else if (q < -SH_W'(32768))
            begin
                round_sat = 16'sh8000;
            end
            else
            begin
                round_sat = q[DATA_W-1:0];
            end
        end
    endfunction

    assign o_load = (state_reg == OUT_EMPTY) || ((state_reg == OUT_SECOND) && result_ready);
    assign b_en   = !b_valid_reg || o_load;
    assign a_en   = !a_valid_reg || b_en;

    assign ea = entry[3*DATA_W-1:2*DATA_W];
    assign es = entry[2*DATA_W-1:DATA_W];
    assign ec = entry[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= a_load;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && a_load)
        begin
            b_reg      <= b_in;
            a_info_reg <= a_info;
        end
        if (b_en)
        begin
            p_ac_reg   <= ea * ec;
            p_bs_reg   <= b_reg * es;
            p_as_reg   <= ea * es;
            p_bc_reg   <= b_reg * ec;
            b_info_reg <= a_info_reg;
        end
        if (o_load && b_valid_reg)
        begin
            rot1_reg   <= rot1;
            rot2_reg   <= rot2;
            o_info_reg <= b_info_reg;
        end
    end

    assign sum1 = SUM_W'(p_ac_reg) - SUM_W'(p_bs_reg);
    assign sum2 = SUM_W'(p_as_reg) + SUM_W'(p_bc_reg);
    assign rot1 = round_sat(sum1);
    assign rot2 = round_sat(sum2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= OUT_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        result_valid  = 1'b0;
        rotated_value = rot1_reg;
        elem_index    = o_info_reg.first_idx;
        vector_done   = 1'b0;
        case (state_reg)
            OUT_EMPTY:
            begin
                if (b_valid_reg)
                begin
                    state_next = OUT_FIRST;
                end
            end
            OUT_FIRST:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    state_next = OUT_SECOND;
                end
            end
            OUT_SECOND:
            begin
                result_valid  = 1'b1;
                rotated_value = rot2_reg;
                elem_index    = o_info_reg.second_idx;
                vector_done   = o_info_reg.last;
                if (result_ready)
                begin
                    state_next = b_valid_reg ? OUT_FIRST : OUT_EMPTY;
                end
            end
            default:
            begin
                state_next = OUT_EMPTY;
            end
        endcase
    end

    `ROPE_ASSERT_NEXT(a_first_then_second, (state_reg == OUT_FIRST) && result_ready, state_reg == OUT_SECOND, "second result of pair not presented after first transfer")
    `ROPE_ASSERT_NOW(a_done_on_second, result_valid && vector_done, state_reg == OUT_SECOND, "vector_done on first result of a pair")
    `ROPE_ASSERT_NEXT(a_stage_b_holds, b_valid_reg && !o_load, b_valid_reg && $stable(p_ac_reg) && $stable(p_bc_reg), "stalled product stage lost its contents")

endmodule

/* design/rotary_embedding_pair_rotate.sv */
// Rotary position embedding: element pair rotation over a streamed vector.
// A pair's second element passes stage A (buffer read) and stage B (products) into the output pair.
// Throughput: one element per cycle while item_ready is high; each pair's two results leave in turn,
// so runs of second elements (split mode) are paced by the output port.
// The pair buffer is a one-write, one-read memory with a registered read port.
// Reset (rst_n, async low) clears position and pipeline valids; buffer contents are not cleared.
module rotary_embedding_pair_rotate
    import rope_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic signed [DATA_W-1:0]  elem_value,
    input  logic signed [DATA_W-1:0]  sine_value,
    input  logic signed [DATA_W-1:0]  cosine_value,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic signed [DATA_W-1:0]  rotated_value,
    output logic [IDX_W-1:0]          elem_index,
    output logic                      vector_done
);

    localparam int SLOT_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    logic              mode_reg;
    logic [HALF_W-1:0] half_reg;
    reg_idx_t          reg_sel;
    logic              cfg_wr;
    logic              item_fire;
    logic              a_en;
    seq_info_t         info;
    logic [SLOT_W-1:0] slot;
    logic [ENTRY_W-1:0] entry;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            half_reg <= HALF_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_MODE: mode_reg <= pwdata[0];
                REG_HALF: half_reg <= pwdata[HALF_W-1:0];
                default:  mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MODE: prdata = {{(PDATA_W-1){1'b0}}, mode_reg};
            REG_HALF: prdata = {{(PDATA_W-HALF_W){1'b0}}, half_reg};
            default:  prdata = '0;
        endcase
    end

    // First elements only write the buffer, so they never wait on the datapath
    assign item_ready = a_en || info.is_first;
    assign item_fire  = item_valid && item_ready;

    rope_seq #(
        .MAX_PAIRS (MAX_PAIRS),
        .SLOT_W    (SLOT_W)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .interleaved_mode (mode_reg),
        .half_length      (half_reg),
        .fire             (item_fire),
        .info             (info),
        .slot             (slot)
    );

    // First element of a pair is stored; the second reads its partner back
    rope_mem #(
        .DEPTH  (MAX_PAIRS),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (item_fire && info.is_first),
        .wr_addr (slot),
        .wr_data ({elem_value, sine_value, cosine_value}),
        .rd_en   (item_fire && !info.is_first),
        .rd_addr (slot),
        .rd_data (entry)
    );

    rope_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .a_load        (item_fire && !info.is_first),
        .a_info        (info),
        .b_in          (elem_value),
        .entry         (entry),
        .a_en          (a_en),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .rotated_value (rotated_value),
        .elem_index    (elem_index),
        .vector_done   (vector_done)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the rotary embedding pair rotator.
module testbench
    import rope_pkg::*;
;

    typedef struct
    {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
        logic                     done;
    } rotated_t;

    // Tracks position and the stored first halves of pairs; queues the rotated results due.
    class pair_rotation_board;
        bit                       interleaved;
        logic [HALF_W-1:0]        half_reg;
        int unsigned              position;
        logic signed [DATA_W-1:0] held_elem [MAX_PAIRS_DEF];
        logic signed [DATA_W-1:0] held_sine [MAX_PAIRS_DEF];
        logic signed [DATA_W-1:0] held_cos [MAX_PAIRS_DEF];
        rotated_t                 rotated_due[$];
        int                       errors;

        function new();
            interleaved = 1'b0;
            half_reg    = HALF_RESET;
            position    = 0;
            errors      = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_MODE: interleaved = val[0];
                REG_HALF: half_reg = val[HALF_W-1:0];
                default: ;
            endcase
        endfunction

        // Q1.14 products back to Q8.8: round half up, then clamp
        function logic signed [DATA_W-1:0] round_sat(longint acc);
            longint q;
            q = (acc + 8192) >>> 14;
            if (q > 32767)
                q = 32767;
            else if (q < -32768)
                q = -32768;
            return DATA_W'(q);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("mismatch: %s", msg);
        endtask

        task take_element(input logic signed [DATA_W-1:0] e, s, c);
            int unsigned span, total, pos, slot, lo_idx, hi_idx;
            bit          leading;
            longint      a, b, sn, cs;
            rotated_t    r;
            span = half_reg;
            if (span < 1)
                span = 1;
            if (span > MAX_PAIRS_DEF)
                span = MAX_PAIRS_DEF;
            total = 2 * span;
            // shrunk vector: restart at position zero
            pos = (position >= total) ? 0 : position;
            if (interleaved)
            begin
                leading = (pos % 2) == 0;
                slot    = pos / 2;
                lo_idx  = pos - (pos % 2);
                hi_idx  = lo_idx + 1;
            end
            else
            begin
                leading = pos < span;
                slot    = leading ? pos : pos - span;
                lo_idx  = slot;
                hi_idx  = slot + span;
            end
            if (slot >= MAX_PAIRS_DEF)
                slot = MAX_PAIRS_DEF - 1;
            position = (pos + 1 >= total) ? 0 : pos + 1;
            if (leading)
            begin
                held_elem[slot] = e;
                held_sine[slot] = s;
                held_cos[slot]  = c;
                return;
            end
            a  = held_elem[slot];
            sn = held_sine[slot];
            cs = held_cos[slot];
            b  = e;
            r.value = round_sat(a * cs - b * sn);
            r.index = IDX_W'(lo_idx);
            r.done  = 1'b0;
            rotated_due.push_back(r);
            r.value = round_sat(a * sn + b * cs);
            r.index = IDX_W'(hi_idx);
            r.done  = (pos + 1 == total);
            rotated_due.push_back(r);
        endtask

        task check_rotated(input logic signed [DATA_W-1:0] v, input logic [IDX_W-1:0] idx,
                           input logic done);
            rotated_t want;
            if (rotated_due.size() == 0)
            begin
                report($sformatf("unexpected result value %0d index %0d done %0b", v, idx, done));
                return;
            end
            want = rotated_due.pop_front();
            if (v !== want.value || idx !== want.index || done !== want.done)
                report($sformatf("got value %0d index %0d done %0b, wanted %0d / %0d / %0b",
                                 v, idx, done, want.value, want.index, want.done));
        endtask
    endclass

    localparam int ITEM_TOTAL = 1450;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     item_valid;
    logic                     item_ready;
    logic signed [DATA_W-1:0] elem_value;
    logic signed [DATA_W-1:0] sine_value;
    logic signed [DATA_W-1:0] cosine_value;
    logic                     result_valid;
    logic                     result_ready;
    logic signed [DATA_W-1:0] rotated_value;
    logic [IDX_W-1:0]         elem_index;
    logic                     vector_done;

    pair_rotation_board board = new();
    int   idle_pct = 30;
    int   items_sent = 0;
    logic hold_go = 1'b0;
    logic hold_active = 1'b0;

    rotary_embedding_pair_rotate dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .elem_value   (elem_value),
        .sine_value   (sine_value),
        .cosine_value (cosine_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .rotated_value(rotated_value),
        .elem_index   (elem_index),
        .vector_done  (vector_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ready <= !hold_active && ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial
    begin
        wait (hold_go);
        @(negedge clk);
        hold_active <= 1'b1;
        repeat (400) @(negedge clk);
        hold_active <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_rotated(rotated_value, elem_index, vector_done);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic signed [DATA_W-1:0] e, s, c);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid   <= 1'b1;
        elem_value   <= e;
        sine_value   <= s;
        cosine_value <= c;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        board.take_element(e, s, c);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random();
        logic signed [DATA_W-1:0] e, s, c;
        if ($urandom_range(0, 9) == 0)
        begin
            e = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            s = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
            c = $urandom_range(0, 1) ? 16'sh4000 : 16'shC000;
        end
        else
        begin
            e = DATA_W'($urandom);
            s = DATA_W'(int'($urandom_range(0, 32768)) - 16384);
            c = DATA_W'(int'($urandom_range(0, 32768)) - 16384);
        end
        send_item(e, s, c);
    endtask

    // Stop offering, wait for every result, then let the pipeline empty.
    task automatic settle();
        item_valid <= 1'b0;
        while (board.rotated_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int unsigned pick, span, count, phase, half_val;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        elem_value   = '0;
        sine_value   = '0;
        cosine_value = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // adjacent pairs, one pair per vector: full-scale and rounding corners
        write_reg(REG_MODE, 32'd1);
        write_reg(REG_HALF, 32'd1);
        send_item(16'sh8000, 16'shC000, 16'sh4000);
        send_item(16'sh8000, 16'sh4000, 16'shC000);
        send_item(16'sh7FFF, 16'sh4000, 16'sh4000);
        send_item(16'sh7FFF, 16'shC000, 16'shC000);
        send_item(16'sh0001, 16'sh0000, 16'sh2000);
        send_item(16'shFFFF, 16'sh0000, 16'sh0000);
        send_item(16'sh8000, 16'sh4000, 16'shC000);
        send_item(16'sh7FFF, 16'sh0001, 16'sh0001);
        settle();

        // half length zero acts as one pair
        write_reg(REG_MODE, 32'd0);
        write_reg(REG_HALF, 32'd0);
        send_random();
        send_random();
        settle();

        // oversized half length clamps; then shrink so the position lies beyond the vector
        write_reg(REG_HALF, 32'd127);
        repeat (5) send_random();
        settle();
        write_reg(REG_HALF, 32'd2);
        repeat (4) send_random();
        settle();

        // mode flipped part way through a vector
        write_reg(REG_MODE, 32'd1);
        send_random();
        settle();
        write_reg(REG_MODE, 32'd0);
        repeat (3) send_random();
        settle();

        // one full split vector fills every pair slot before the random part
        write_reg(REG_HALF, 32'd64);
        repeat (128) send_random();

        phase = 0;
        while (items_sent < ITEM_TOTAL)
        begin
            settle();
            pick = $urandom_range(0, 99);
            if (pick < 60)
                half_val = $urandom_range(1, 8);
            else if (pick < 80)
                half_val = $urandom_range(9, 63);
            else if (pick < 88)
                half_val = 64;
            else if (pick < 94)
                half_val = 0;
            else
                half_val = $urandom_range(65, 127);
            write_reg(REG_MODE, 32'($urandom_range(0, 1)));
            write_reg(REG_HALF, half_val);
            span = (half_val < 1) ? 1 : (half_val > MAX_PAIRS_DEF) ? MAX_PAIRS_DEF : half_val;
            count = (2 * span >= 100) ? 2 * span : 2 * span * $urandom_range(1, 4);
            // sometimes stop part way through a vector
            if ($urandom_range(0, 3) == 0)
                count += $urandom_range(1, 2 * span - 1 + (span == 1));
            idle_pct = (phase == 3) ? 0 : 30;
            if (phase == 5)
            begin
                if (count < 150)
                    count = 150;
                hold_go = 1'b1;
            end
            repeat (count) send_random();
            phase++;
        end
        settle();
        repeat (20) @(negedge clk);

        if (board.rotated_due.size() != 0)
            board.report($sformatf("%0d results never arrived", board.rotated_due.size()));
        if (board.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
